// File: hw/rtl/psfi_pkg.sv
// Package for the pair sub-basis first-seen indexer.
// Holds the item structs, opcodes, register indexes and fixed widths.
// Used by the top level, the scoreboard and the testbench; depends on nothing.
package psfi_pkg;

	// Opcodes
	localparam logic OP_INDEX = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_DIM  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_DIM = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SITE_DIM  = 2'd2;

	// Register widths and reset values
	localparam int unsigned BLK_DIM_W = 9;
	localparam int unsigned SITE_DIM_W = 5;
	localparam int unsigned CFG_DATA_W = 9;
	localparam logic [BLK_DIM_W-1:0]  LEFT_DIM_RST  = 9'd256;
	localparam logic [BLK_DIM_W-1:0]  RIGHT_DIM_RST = 9'd256;
	localparam logic [SITE_DIM_W-1:0] SITE_DIM_RST  = 5'd16;

	// Width of the dense index buses; each map's index wraps at its own address width
	localparam int unsigned IDX_W = 17;

	// Appearance count
	localparam int unsigned CNT_W = 13;
	localparam logic [CNT_W-1:0] COUNT_MAX = 13'd8191;

	typedef struct packed {
		logic       opcode;
		logic [7:0] left_block;
		logic [3:0] left_site;
		logic [7:0] right_block;
		logic [3:0] right_site;
	} in_item_t;

	typedef struct packed {
		logic [11:0]      lb_ls_index;
		logic [15:0]      lb_rb_index;
		logic [11:0]      lb_rs_index;
		logic [11:0]      ls_rb_index;
		logic [7:0]       ls_rs_index;
		logic [11:0]      rb_rs_index;
		logic [5:0]       new_mask;
		logic [CNT_W-1:0] lb_ls_count;
		logic             out_of_range;
	} out_item_t;

endpackage

// File: hw/rtl/psfi_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for every pair map and the appearance count store; no dependencies.
module psfi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port; data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: hw/rtl/pair_subbasis_first_seen_indexer.sv
// Pair sub-basis first-seen indexer, top level.
// An item passes through the map lookup, the count lookup and the result load before its
// result enters the output register; a clear or an out-of-range tuple skips the count lookup.
// The count memory is read at the index that the left-block/left-site map returns, and a
// new item is accepted only once the previous one has left the result stage, which waits
// while the output register is full and not taken. After reset and after every clear item
// a sweep writes all six pair maps to unseen, one entry per cycle in parallel, through
// max(MAX_BLOCK_STATES^2, MAX_SITE_STATES^2) addresses (65536 at the defaults); no item is
// accepted during the sweep, configuration writes are. A finished result waits in the
// output register while the next item is accepted. Depends on psfi_pkg, psfi_ram.
module pair_subbasis_first_seen_indexer
	import psfi_pkg::*;
#(
	parameter int MAX_BLOCK_STATES = 256,
	parameter int MAX_SITE_STATES  = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int NUM_MAPS = 6;
	// Parts: 0 left block, 1 left site, 2 right block, 3 right site
	localparam int PART_DIM [4] = '{MAX_BLOCK_STATES, MAX_SITE_STATES,
		MAX_BLOCK_STATES, MAX_SITE_STATES};
	localparam int FIRST_PART [NUM_MAPS] = '{0, 0, 0, 1, 1, 2};
	localparam int SECOND_PART [NUM_MAPS] = '{1, 2, 3, 2, 3, 3};

	localparam int BB_DEPTH = MAX_BLOCK_STATES * MAX_BLOCK_STATES;
	localparam int SS_DEPTH = MAX_SITE_STATES * MAX_SITE_STATES;
	localparam int SWEEP_DEPTH = (BB_DEPTH > SS_DEPTH) ? BB_DEPTH : SS_DEPTH;
	localparam int SW = $clog2(SWEEP_DEPTH);
	localparam int CNT_DEPTH = MAX_BLOCK_STATES * MAX_SITE_STATES;
	localparam int CAW = $clog2(CNT_DEPTH);

	localparam logic [12:0] BLK_LIM = 13'(MAX_BLOCK_STATES);
	localparam logic [6:0] SITE_LIM = 7'(MAX_SITE_STATES);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOOK = 2'd1;
	localparam logic [1:0] ST_CNT  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0] state_q;
	logic [BLK_DIM_W-1:0] left_dim_q, right_dim_q;
	logic [SITE_DIM_W-1:0] site_dim_q;
	logic sweep_q;
	logic [SW-1:0] sweep_cnt_q;
	logic op_q, oor_q, new0_q;
	logic [CAW-1:0] cnt_addr_q;
	out_item_t res_q;
	out_item_t res_look;
	out_item_t out_data_q;
	logic out_valid_q;

	logic accept, look_go, oor_d, slot_free;
	logic [7:0] part [4];
	logic [IDX_W-1:0] idx_all [NUM_MAPS];
	logic [NUM_MAPS-1:0] new_vec;
	logic [CNT_W-1:0] cnt_rd, cnt_next;

	assign in_ready = (state_q == ST_IDLE) && !sweep_q;
	assign accept = in_valid && in_ready;
	assign look_go = (state_q == ST_LOOK) && (op_q == OP_INDEX) && !oor_q;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	assign part[0] = in_data.left_block;
	assign part[1] = {4'd0, in_data.left_site};
	assign part[2] = in_data.right_block;
	assign part[3] = {4'd0, in_data.right_site};

	// Flag a tuple beyond the configured or built-in dimensions
	always_comb begin
		oor_d = ({1'b0, in_data.left_block} >= left_dim_q)
			|| (13'(in_data.left_block) >= BLK_LIM)
			|| ({1'b0, in_data.right_block} >= right_dim_q)
			|| (13'(in_data.right_block) >= BLK_LIM)
			|| ({1'b0, in_data.left_site} >= site_dim_q)
			|| (7'(in_data.left_site) >= SITE_LIM)
			|| ({1'b0, in_data.right_site} >= site_dim_q)
			|| (7'(in_data.right_site) >= SITE_LIM);
	end

	// Configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_dim_q <= LEFT_DIM_RST;
			right_dim_q <= RIGHT_DIM_RST;
			site_dim_q <= SITE_DIM_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LEFT_DIM: left_dim_q <= cfg_data[BLK_DIM_W-1:0];
				REG_RIGHT_DIM: right_dim_q <= cfg_data[BLK_DIM_W-1:0];
				REG_SITE_DIM: site_dim_q <= cfg_data[SITE_DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Pair maps: each entry is {seen, index}; read at accept, write back in lookup
	for (genvar k = 0; k < NUM_MAPS; k++) begin : g_map
		localparam int DS = PART_DIM[SECOND_PART[k]];
		localparam int DEPTH = PART_DIM[FIRST_PART[k]] * DS;
		localparam int AW = $clog2(DEPTH);
		localparam int IW = (AW < IDX_W) ? AW : IDX_W;

		logic [AW-1:0] addr_d, addr_q, wr_addr;
		logic [IW:0] ent, wr_ent;
		logic [IW-1:0] next_q;
		logic wr_en, in_sweep;

		assign addr_d = AW'(part[FIRST_PART[k]]) * AW'(DS) + AW'(part[SECOND_PART[k]]);
		assign in_sweep = {1'b0, sweep_cnt_q} < (SW + 1)'(DEPTH);
		assign new_vec[k] = !ent[IW];
		assign idx_all[k] = IDX_W'(ent[IW] ? ent[IW-1:0] : next_q);

		// Sweep to unseen, or record a first sighting
		always_comb begin
			if (sweep_q) begin
				wr_en = in_sweep;
				wr_addr = AW'(sweep_cnt_q);
				wr_ent = '0;
			end else begin
				wr_en = look_go && !ent[IW];
				wr_addr = addr_q;
				wr_ent = {1'b1, next_q};
			end
		end

		// Hold the lookup address for the write-back
		always_ff @(posedge clk) begin
			if (accept) begin
				addr_q <= addr_d;
			end
		end

		// Advance the next dense index on a new pair; zero it on clear
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				next_q <= '0;
			end else if (state_q == ST_LOOK && op_q == OP_CLEAR) begin
				next_q <= '0;
			end else if (look_go && !ent[IW]) begin
				next_q <= next_q + 1'b1;
			end
		end

		psfi_ram #(
			.WIDTH(IW + 1),
			.DEPTH(DEPTH)
		) u_map (
			.clk(clk),
			.wr_en(wr_en),
			.wr_addr(wr_addr),
			.wr_data(wr_ent),
			.rd_en(accept),
			.rd_addr(addr_d),
			.rd_data(ent)
		);
	end

	// Appearance count, saturating
	always_comb begin
		if (new0_q) begin
			cnt_next = CNT_W'(1);
		end else if (cnt_rd < COUNT_MAX) begin
			cnt_next = cnt_rd + 1'b1;
		end else begin
			cnt_next = cnt_rd;
		end
	end

	psfi_ram #(
		.WIDTH(CNT_W),
		.DEPTH(CNT_DEPTH)
	) u_count (
		.clk(clk),
		.wr_en(state_q == ST_CNT),
		.wr_addr(cnt_addr_q),
		.wr_data(cnt_next),
		.rd_en(look_go),
		.rd_addr(CAW'(idx_all[0])),
		.rd_data(cnt_rd)
	);

	// Clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= 1'b1;
			sweep_cnt_q <= '0;
		end else if (state_q == ST_LOOK && op_q == OP_CLEAR) begin
			sweep_q <= 1'b1;
			sweep_cnt_q <= '0;
		end else if (sweep_q) begin
			sweep_cnt_q <= sweep_cnt_q + 1'b1;
			if (sweep_cnt_q == SW'(SWEEP_DEPTH - 1)) begin
				sweep_q <= 1'b0;
			end
		end
	end

	// Item sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: state_q <= look_go ? ST_CNT : ST_DONE;
				ST_CNT: state_q <= ST_DONE;
				ST_DONE: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Build the lookup result; clear items leave it all zero
	always_comb begin
		res_look = '0;
		if (op_q == OP_INDEX && oor_q) begin
			res_look.out_of_range = 1'b1;
		end else if (look_go) begin
			res_look.lb_ls_index = 12'(idx_all[0]);
			res_look.lb_rb_index = 16'(idx_all[1]);
			res_look.lb_rs_index = 12'(idx_all[2]);
			res_look.ls_rb_index = 12'(idx_all[3]);
			res_look.ls_rs_index = 8'(idx_all[4]);
			res_look.rb_rs_index = 12'(idx_all[5]);
			res_look.new_mask = new_vec;
		end
	end

	// Capture item flags and hold the result
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= in_data.opcode;
			oor_q <= oor_d;
		end
		if (state_q == ST_LOOK) begin
			res_q <= res_look;
			new0_q <= new_vec[0];
			cnt_addr_q <= CAW'(idx_all[0]);
		end
		if (state_q == ST_CNT) begin
			res_q.lb_ls_count <= cnt_next;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && slot_free) begin
			out_data_q <= res_q;
		end
	end

endmodule

// File: tb/psfi_board_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the pair sub-basis first-seen indexer testbench.
// Predicts the six pair indices, new mask and appearance count for each accepted item.
// Depends on psfi_pkg for the item structs, opcodes and register indexes.
package psfi_board_pkg;
	import psfi_pkg::*;

	class first_seen_board;
		// Register copies
		logic [BLK_DIM_W-1:0]  left_dim = LEFT_DIM_RST;
		logic [BLK_DIM_W-1:0]  right_dim = RIGHT_DIM_RST;
		logic [SITE_DIM_W-1:0] site_dim = SITE_DIM_RST;

		// Pair maps keyed by {map id, address}; absent key means unseen
		bit [IDX_W-1:0] first_index[int];
		bit [CNT_W-1:0] lb_ls_hits[int];
		bit [IDX_W-1:0] next_index[6];
		bit [5:0]       new_bits;

		out_item_t pending_results[$];
		int        errors;

		function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_LEFT_DIM:  left_dim = val;
				REG_RIGHT_DIM: right_dim = val;
				REG_SITE_DIM:  site_dim = val[SITE_DIM_W-1:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function void report(string msg);
			errors++;
			$display("mismatch @%0t: %s", $realtime, msg);
		endfunction

		function void wipe_maps();
			first_index.delete();
			lb_ls_hits.delete();
			foreach (next_index[k])
				next_index[k] = '0;
		endfunction

		// Look up one pair, hand out the next index of its map when unseen
		function bit [IDX_W-1:0] claim_index(int map_id, int addr);
			int             key;
			bit [IDX_W-1:0] got;
			key = (map_id << 16) | addr;
			if (first_index.exists(key))
				return first_index[key];
			got = next_index[map_id];
			first_index[key] = got;
			next_index[map_id] = got + 1'b1;
			new_bits[map_id] = 1'b1;
			return got;
		endfunction

		function out_item_t predict_pair_indices(in_item_t it);
			out_item_t      r;
			bit [IDX_W-1:0] idx[6];
			bit [CNT_W-1:0] cnt;
			int             slot;
			r = '0;
			if (it.opcode == OP_CLEAR) begin
				wipe_maps();
				return r;
			end
			if (it.left_block >= left_dim || it.right_block >= right_dim ||
					it.left_site >= site_dim || it.right_site >= site_dim) begin
				r.out_of_range = 1'b1;
				return r;
			end
			new_bits = '0;
			idx[0] = claim_index(0, int'({it.left_block, it.left_site}));
			idx[1] = claim_index(1, int'({it.left_block, it.right_block}));
			idx[2] = claim_index(2, int'({it.left_block, it.right_site}));
			idx[3] = claim_index(3, int'({it.left_site, it.right_block}));
			idx[4] = claim_index(4, int'({it.left_site, it.right_site}));
			idx[5] = claim_index(5, int'({it.right_block, it.right_site}));
			// Count appearances per lb_ls index, saturating
			slot = int'(idx[0][11:0]);
			if (new_bits[0]) begin
				cnt = CNT_W'(1);
			end else begin
				cnt = lb_ls_hits[slot];
				if (cnt < COUNT_MAX)
					cnt++;
			end
			lb_ls_hits[slot] = cnt;
			r.lb_ls_index = idx[0][11:0];
			r.lb_rb_index = idx[1][15:0];
			r.lb_rs_index = idx[2][11:0];
			r.ls_rb_index = idx[3][11:0];
			r.ls_rs_index = idx[4][7:0];
			r.rb_rs_index = idx[5][11:0];
			r.new_mask = new_bits;
			r.lb_ls_count = cnt;
			return r;
		endfunction

		function void note_tuple(in_item_t it);
			pending_results = {pending_results, predict_pair_indices(it)};
		endfunction

		function void compare(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report($sformatf("%s got %0h want %0h", name, got, want));
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (pending_results.size() == 0) begin
				report("result arrived with no item waiting");
				return;
			end
			want = pending_results.pop_front();
			compare("lb_ls_index", 32'(got.lb_ls_index), 32'(want.lb_ls_index));
			compare("lb_rb_index", 32'(got.lb_rb_index), 32'(want.lb_rb_index));
			compare("lb_rs_index", 32'(got.lb_rs_index), 32'(want.lb_rs_index));
			compare("ls_rb_index", 32'(got.ls_rb_index), 32'(want.ls_rb_index));
			compare("ls_rs_index", 32'(got.ls_rs_index), 32'(want.ls_rs_index));
			compare("rb_rs_index", 32'(got.rb_rs_index), 32'(want.rb_rs_index));
			compare("new_mask", 32'(got.new_mask), 32'(want.new_mask));
			compare("lb_ls_count", 32'(got.lb_ls_count), 32'(want.lb_ls_count));
			compare("out_of_range", 32'(got.out_of_range), 32'(want.out_of_range));
		endfunction
	endclass

endpackage

// File: tb/pair_subbasis_first_seen_indexer_tb.sv
`timescale 1ns / 100ps
// Testbench top for the pair sub-basis first-seen indexer.
// Drives directed and random tuples under several dimension settings with random idling.
// Depends on psfi_pkg, psfi_board_pkg and the indexer RTL.
module pair_subbasis_first_seen_indexer_tb;
	import psfi_pkg::*;
	import psfi_board_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int LIMIT = 3000000;
	localparam int PHASES = 7;
	localparam int PHASE_ITEMS = 190;
	localparam int SATURATE_ITEMS = 100;
	localparam int SQUEEZE_CYCLES = 600;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	in_item_t              in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_item_t             out_data;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	first_seen_board board = new();
	bit steady = 1'b0;
	int squeeze_asked = 0;
	int cycles = 0;

	// Dimension settings per random phase
	int phase_left[PHASES]  = '{256, 4, 1, 256, 300, 17, 256};
	int phase_right[PHASES] = '{256, 3, 256, 1, 2, 200, 256};
	int phase_site[PHASES]  = '{16, 2, 16, 1, 31, 5, 16};

	pair_subbasis_first_seen_indexer u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Bound the run
	initial begin
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// Accept results, idle at random, hold off for a long stretch when asked
	initial begin : result_sink
		int hold;
		int squeeze_done;
		hold = 0;
		squeeze_done = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				board.check_result(out_data);
			if (squeeze_done != squeeze_asked) begin
				squeeze_done = squeeze_asked;
				hold = SQUEEZE_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= steady || ($urandom_range(99) >= 34);
			end
		end
	end

	function automatic in_item_t tup(int lb, int ls, int rb, int rs);
		in_item_t it;
		it.opcode = OP_INDEX;
		it.left_block = 8'(lb);
		it.left_site = 4'(ls);
		it.right_block = 8'(rb);
		it.right_site = 4'(rs);
		return it;
	endfunction

	function automatic in_item_t clear_item();
		in_item_t it;
		it = tup($urandom, $urandom, $urandom, $urandom);
		it.opcode = OP_CLEAR;
		return it;
	endfunction

	function automatic int pick_part(int n, bit hot);
		return hot ? $urandom_range(n > 6 ? 5 : n - 1) : $urandom_range(n - 1);
	endfunction

	// Mostly in-range tuples, a hot corner for repeats, the rest noise
	function automatic in_item_t rand_tuple(int ld, int rd, int sd);
		in_item_t it;
		int       roll;
		bit       hot;
		it = tup($urandom, $urandom, $urandom, $urandom);
		roll = $urandom_range(99);
		hot = roll < 40;
		if (roll < 88 && ld > 0 && rd > 0 && sd > 0) begin
			it.left_block = 8'(pick_part(ld, hot));
			it.left_site = 4'(pick_part(sd, hot));
			it.right_block = 8'(pick_part(rd, hot));
			it.right_site = 4'(pick_part(sd, hot));
		end
		return it;
	endfunction

	// Offer one item after an optional gap, hold it until accepted
	task automatic push_item(in_item_t it);
		if (!steady && $urandom_range(99) < 34) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 34);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		board.note_tuple(it);
	endtask

	// Drop valid, wait for every outstanding result, then idle before the next block
	task automatic settle_block();
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_dims(logic [8:0] l, logic [8:0] r, logic [8:0] s, bit poke_unused);
		cfg_we <= 1'b1;
		cfg_index <= REG_LEFT_DIM;
		cfg_data <= l;
		@(posedge clk);
		board.apply_reg(REG_LEFT_DIM, l);
		cfg_index <= REG_RIGHT_DIM;
		cfg_data <= r;
		@(posedge clk);
		board.apply_reg(REG_RIGHT_DIM, r);
		cfg_index <= REG_SITE_DIM;
		cfg_data <= s;
		@(posedge clk);
		board.apply_reg(REG_SITE_DIM, s);
		if (poke_unused) begin
			cfg_index <= REG_UNUSED;
			cfg_data <= CFG_DATA_W'($urandom);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		int ld;
		int rd;
		int sd;
		int clear_at;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		write_dims(9'd256, 9'd256, 9'd16, 1'b1);

		// Extremes at the default dimensions
		push_item(tup(0, 0, 0, 0));
		push_item(tup(0, 0, 0, 0));
		push_item(tup(255, 15, 255, 15));
		push_item(tup(255, 15, 255, 15));
		push_item(tup(0, 15, 255, 0));
		push_item(tup(255, 0, 0, 15));

		// Smallest dimensions: each part out of range on its own
		settle_block();
		write_dims(9'd1, 9'd1, 9'd1, 1'b0);
		push_item(tup(0, 0, 0, 0));
		push_item(tup(1, 0, 0, 0));
		push_item(tup(0, 1, 0, 0));
		push_item(tup(0, 0, 1, 0));
		push_item(tup(0, 0, 0, 1));
		push_item(tup(255, 15, 255, 15));

		// Zero dimension flags everything
		settle_block();
		write_dims(9'd0, 9'd256, 9'd16, 1'b0);
		push_item(tup(0, 0, 0, 0));

		// Oversized values act as the maximum; maps survive register writes
		settle_block();
		write_dims(9'h1FF, 9'h100, 9'h1F0, 1'b1);
		push_item(tup(255, 15, 255, 15));
		push_item(tup(255, 15, 255, 15));
		push_item(clear_item());
		push_item(tup(255, 15, 255, 15));
		push_item(tup(7, 7, 7, 7));
		push_item(tup(0, 0, 0, 0) | {1'b1, 24'h0});
		push_item(tup(7, 7, 7, 7));

		// Drive one lb_ls pair repeatedly at full rate
		settle_block();
		write_dims(9'd256, 9'd256, 9'd16, 1'b0);
		steady = 1'b1;
		push_item(clear_item());
		for (int i = 0; i < SATURATE_ITEMS; i++)
			push_item(tup(9, 3, $urandom, $urandom));
		steady = 1'b0;

		// Random phases over several dimension settings
		for (int p = 0; p < PHASES; p++) begin
			settle_block();
			write_dims(9'(phase_left[p]), 9'(phase_right[p]), 9'(phase_site[p]), p == 3);
			ld = phase_left[p] > 256 ? 256 : phase_left[p];
			rd = phase_right[p] > 256 ? 256 : phase_right[p];
			sd = phase_site[p] & 31;
			sd = sd > 16 ? 16 : sd;
			steady = (p == 1);
			clear_at = (p % 2 == 0 && p < 6) ? $urandom_range(180, 30) : -1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 0 && i == 20)
					squeeze_asked++;
				if (i == clear_at)
					push_item(clear_item());
				else
					push_item(rand_tuple(ld, rd, sd));
			end
		end
		steady = 1'b0;

		settle_block();
		repeat (12) @(posedge clk);
		if (board.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: files.f
hw/rtl/psfi_pkg.sv
hw/rtl/psfi_ram.sv
hw/rtl/pair_subbasis_first_seen_indexer.sv
tb/psfi_board_pkg.sv
tb/pair_subbasis_first_seen_indexer_tb.sv
